// File: rtl/bgas_pkg.sv
// Package for the battery guard alarm sequencer.
// Holds the state and condition types, register map codes and shared constants.
// No dependencies.
package bgas_pkg;

  localparam int ADC_BITS_DEF = 12;
  localparam int RAW_BITS_DEF = 24;
  localparam int LIMIT_BITS   = 16;
  localparam int ADDR_W       = 5;
  localparam int DATA_W       = 32;
  localparam int CNT_W        = 7;

  // Default thresholds as 12-bit codes at 3.3 V full scale over 4095 codes.
  localparam int REF_FULL_CODE      = 4095;
  localparam int TEMP_EXTREME_CODE  = 1638;
  localparam int TEMP_HIGH_CODE     = 1799;
  localparam int BATT_FULL_CODE     = 4083;
  localparam int SCALE_TARE_DEF     = 0;
  localparam int SCALE_SPAN_DEF     = 8493860;
  localparam int WEIGHT_LIMIT_DEF   = 105;

  localparam logic [CNT_W-1:0] WEIGHT_SAT  = CNT_W'(80);
  localparam logic [CNT_W-1:0] WEIGHT_W1LO = CNT_W'(20);
  localparam logic [CNT_W-1:0] WEIGHT_W1HI = CNT_W'(40);
  localparam logic [CNT_W-1:0] WEIGHT_W2LO = CNT_W'(40);
  localparam logic [CNT_W-1:0] WEIGHT_W2HI = CNT_W'(60);

  typedef enum logic [1:0] {
    TEMP_FINE    = 2'd0,
    TEMP_HIGH    = 2'd1,
    TEMP_EXTREME = 2'd2
  } temp_status_t;

  typedef enum logic [2:0] {
    REG_TEMP_EXTREME = 3'd0,
    REG_TEMP_HIGH    = 3'd1,
    REG_BATT_FULL    = 3'd2,
    REG_SCALE_TARE   = 3'd3,
    REG_SCALE_SPAN   = 3'd4,
    REG_WEIGHT_LIMIT = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic             tick_phase;
    logic             blink;
    logic [CNT_W-1:0] weight_ticks;
    logic             full_latch;
    logic             beep;
    logic             motor;
    logic             trig;
  } guard_state_t;

  typedef struct packed {
    temp_status_t status;
    logic         over;
    logic         full_hit;
  } guard_cond_t;

endpackage

// File: rtl/battery_guard_alarm_sequencer.sv
// Battery guard alarm sequencer: one request per cycle unless stalled; a result per request.
// A request is held in the input stage; its result then loads the output registers.
// One request per clock while results are taken; the result register frees as each is taken.
// The weight threshold product is formed from the registers in the cycle after they change.
// Synchronous active-high reset loads register defaults and clears state, not drive outputs.
module battery_guard_alarm_sequencer #(
  parameter int ADC_BITS = bgas_pkg::ADC_BITS_DEF,
  parameter int RAW_BITS = bgas_pkg::RAW_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [bgas_pkg::ADDR_W-1:0] paddr,
  input  logic [bgas_pkg::DATA_W-1:0] pwdata,
  output logic [bgas_pkg::DATA_W-1:0] prdata,
  output logic                      pready,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [ADC_BITS-1:0]       temp_code,
  input  logic [ADC_BITS-1:0]       battery_code,
  input  logic [RAW_BITS-1:0]       scale_raw,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      beep,
  output logic                      led,
  output logic                      motor,
  output logic                      trigger_out,
  output logic [1:0]                temp_status,
  output logic                      weight_over,
  output logic                      shutoff_latched
);
  import bgas_pkg::*;

  localparam int ADC_MAX = (1 << ADC_BITS) - 1;
  localparam logic [ADC_BITS-1:0] TEMP_EXTREME_RST =
    ADC_BITS'((TEMP_EXTREME_CODE * ADC_MAX) / REF_FULL_CODE);
  localparam logic [ADC_BITS-1:0] TEMP_HIGH_RST =
    ADC_BITS'((TEMP_HIGH_CODE * ADC_MAX) / REF_FULL_CODE);
  localparam logic [ADC_BITS-1:0] BATT_FULL_RST =
    ADC_BITS'((BATT_FULL_CODE * ADC_MAX) / REF_FULL_CODE);
  localparam int DEN_W = RAW_BITS + LIMIT_BITS;
  localparam int CMP_W = DEN_W + 1;

  logic [ADC_BITS-1:0]   temp_extreme_below;
  logic [ADC_BITS-1:0]   temp_high_at_most;
  logic [ADC_BITS-1:0]   battery_full_at_least;
  logic [RAW_BITS-1:0]   scale_tare;
  logic [RAW_BITS-1:0]   scale_span_raw;
  logic [LIMIT_BITS-1:0] weight_limit;

  logic [DEN_W-1:0]      den;
  logic                  span_ok;

  logic                  s1_valid;
  logic [ADC_BITS-1:0]   s1_temp;
  logic [ADC_BITS-1:0]   s1_batt;
  logic [RAW_BITS-1:0]   s1_raw;

  guard_state_t          st;
  guard_state_t          st_next;
  guard_cond_t           cond;

  logic                  advance;
  logic                  cfg_write;
  reg_index_t            cfg_index;
  logic [RAW_BITS:0]     raw_diff;
  logic [CMP_W-1:0]      raw_diff_ext;
  logic [CMP_W-1:0]      num;
  temp_status_t          status;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_index = reg_index_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_extreme_below    <= TEMP_EXTREME_RST;
      temp_high_at_most     <= TEMP_HIGH_RST;
      battery_full_at_least <= BATT_FULL_RST;
      scale_tare            <= RAW_BITS'(SCALE_TARE_DEF);
      scale_span_raw        <= RAW_BITS'(SCALE_SPAN_DEF);
      weight_limit          <= LIMIT_BITS'(WEIGHT_LIMIT_DEF);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TEMP_EXTREME: temp_extreme_below    <= pwdata[ADC_BITS-1:0];
        REG_TEMP_HIGH:    temp_high_at_most     <= pwdata[ADC_BITS-1:0];
        REG_BATT_FULL:    battery_full_at_least <= pwdata[ADC_BITS-1:0];
        REG_SCALE_TARE:   scale_tare            <= pwdata[RAW_BITS-1:0];
        REG_SCALE_SPAN:   scale_span_raw        <= pwdata[RAW_BITS-1:0];
        REG_WEIGHT_LIMIT: weight_limit          <= pwdata[LIMIT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_index)
      REG_TEMP_EXTREME: prdata = DATA_W'(temp_extreme_below);
      REG_TEMP_HIGH:    prdata = DATA_W'(temp_high_at_most);
      REG_BATT_FULL:    prdata = DATA_W'(battery_full_at_least);
      REG_SCALE_TARE:   prdata = DATA_W'(scale_tare);
      REG_SCALE_SPAN:   prdata = DATA_W'(scale_span_raw);
      REG_WEIGHT_LIMIT: prdata = DATA_W'(weight_limit);
      default:          prdata = '0;
    endcase
  end

  // The threshold product depends on the registers only.
  always_ff @(posedge clk) begin
    den     <= DEN_W'(weight_limit * (scale_span_raw - scale_tare));
    span_ok <= (scale_span_raw > scale_tare);
  end

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_temp <= temp_code;
      s1_batt <= battery_code;
      s1_raw  <= scale_raw;
    end
  end

  always_comb begin
    if (s1_temp < temp_extreme_below) begin
      status = TEMP_EXTREME;
    end else if (s1_temp <= temp_high_at_most) begin
      status = TEMP_HIGH;
    end else begin
      status = TEMP_FINE;
    end
  end

  assign raw_diff     = {1'b0, s1_raw} - {1'b0, scale_tare};
  assign raw_diff_ext = CMP_W'($signed(raw_diff));
  assign num          = (raw_diff_ext << 6) + (raw_diff_ext << 5) + (raw_diff_ext << 2);

  assign cond.status   = status;
  assign cond.over     = span_ok && ($signed(num) >= $signed({1'b0, den}));
  assign cond.full_hit = (s1_batt >= battery_full_at_least);

  bgas_rules u_rules (
    .st      (st),
    .cond    (cond),
    .st_next (st_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        st <= st_next;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      beep            <= st_next.beep;
      motor           <= st_next.motor;
      trigger_out     <= st_next.trig;
      temp_status     <= status;
      weight_over     <= cond.over;
      shutoff_latched <= st_next.full_latch;
    end
  end

  assign led = beep;

`ifndef SYNTHESIS
  a_latch_sticky: assert property (@(posedge clk) disable iff (rst)
    st.full_latch |=> st.full_latch)
    else $error("shutoff latch cleared");

  a_trig_cut_when_latched: assert property (@(posedge clk) disable iff (rst)
    st.full_latch |-> !st.trig)
    else $error("trigger connected while shutoff latched");

  a_weight_saturates: assert property (@(posedge clk) disable iff (rst)
    st.weight_ticks <= WEIGHT_SAT)
    else $error("weight counter above saturation");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("processed request produced no result");
`endif

endmodule

// File: rtl/bgas_rules.sv
// Next-state rules of the alarm sequencer for one request.
// Applies the ordered drive rules to the current state and this request's conditions.
// Depends on bgas_pkg.
module bgas_rules (
  input  bgas_pkg::guard_state_t st,
  input  bgas_pkg::guard_cond_t  cond,
  output bgas_pkg::guard_state_t st_next
);
  import bgas_pkg::*;

  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] inc;
    inc = v + CNT_W'(1);
    return (inc >= WEIGHT_SAT) ? WEIGHT_SAT : inc;
  endfunction

  always_comb begin
    guard_state_t s;
    logic t;
    logic b;
    logic w;
    logic l;
    logic ph;
    s = st;
    t = (cond.status == TEMP_HIGH);
    b = (cond.status == TEMP_EXTREME);
    w = cond.over;
    if (cond.full_hit) begin
      s.trig = 1'b0;
      s.full_latch = 1'b1;
    end
    l = s.full_latch;

    if (st.tick_phase) begin
      s.tick_phase = 1'b0;
      s.blink = ~st.blink;
      if (t && !b && !l) begin
        s.beep = s.blink;
      end else if (!t && !b && !l) begin
        s.beep = 1'b0;
        s.trig = 1'b1;
      end
      if (!t && !b && w && !l) begin
        s.weight_ticks = bump(s.weight_ticks);
        if (s.weight_ticks >= WEIGHT_W1LO && s.weight_ticks <= WEIGHT_W1HI) begin
          s.beep = s.blink;
        end
      end else if (!t && !b && !w && !l) begin
        s.weight_ticks = '0;
        s.beep = 1'b0;
      end
    end else begin
      s.tick_phase = 1'b1;
    end
    ph = s.tick_phase;

    if (!b && t && !l) begin
      s.motor = ph;
    end

    if (b && !t && !l) begin
      s.trig = 1'b0;
      s.motor = 1'b1;
      s.beep = ph;
    end else if (!b && !t && !w) begin
      s.motor = 1'b0;
      s.beep = 1'b0;
    end

    if (!t && !b && w) begin
      s.weight_ticks = bump(s.weight_ticks);
      if (s.weight_ticks >= WEIGHT_W2LO && s.weight_ticks <= WEIGHT_W2HI) begin
        s.beep = ph;
      end else if (s.weight_ticks >= WEIGHT_SAT) begin
        s.trig = 1'b0;
        s.beep = 1'b1;
      end
    end else if (!t && !b && !w && !l) begin
      s.weight_ticks = '0;
      s.beep = 1'b0;
    end

    if (!t && !b && !w && l) begin
      s.beep = ph;
    end else if (!t && !b && !w && !l) begin
      s.weight_ticks = '0;
      s.beep = 1'b0;
    end

    st_next = s;
  end

endmodule
